/* rtl/sbsi_pkg.sv */
// ----------------------------------------------------------------------------
// sbsi_pkg
// Shared constants and types for the segment / box slab intersection block.
// ----------------------------------------------------------------------------
package sbsi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_AXES      = 3;
    localparam int COORD_W       = 31;
    localparam int DIFF_W        = 32;
    localparam int THR_W         = 16;
    localparam int HIT_T_W       = 17;
    localparam int AXIS_W        = 2;
    localparam int IN_TDATA_W    = 376;
    localparam int OUT_TDATA_W   = 120;
    localparam int MERGE_LAT     = 4;

    localparam logic [THR_W-1:0] THR_RESET = 16'd1;

    typedef logic [AXIS_W-1:0] t_axis;
    localparam t_axis AXIS_X    = 2'd0;
    localparam t_axis AXIS_Y    = 2'd1;
    localparam t_axis AXIS_Z    = 2'd2;
    localparam t_axis AXIS_NONE = 2'd3;

    // per-axis status that travels beside the slab parameters
    typedef struct packed {
        logic par;      // direction too small, no slab test, inside/outside check only
        logic outside;  // start lies outside [min, max]
    } t_axis_flags;

endpackage

/* rtl/segment_box_slab_intersection_top.sv */
// Throughput: one request per cycle unless a held result stalls the pipe; each axis
// lane holds two restoring dividers that resolve one quotient bit per pipeline stage,
// which sets the pipeline depth.
// Reset (i_rst_n low, synchronous): drop every in-flight request, clear the output
// valid and load parallel_threshold with 1.
// ----------------------------------------------------------------------------
// segment_box_slab_intersection_top
// Segment versus axis-aligned box slab test, three axis lanes and a merge pipe.
// ----------------------------------------------------------------------------
module segment_box_slab_intersection_top
    import sbsi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: parallel_threshold
    input  logic                   i_cfg_wr_en,
    input  logic [THR_W-1:0]       i_cfg_wr_data,
    // request stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata, low bit up: seg_start_x, seg_start_y, seg_start_z, seg_end_x,
    // seg_end_y, seg_end_z, box_min_x, box_min_y, box_min_z, box_max_x,
    // box_max_y, box_max_z (31 bits each), 4 bits zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata, low bit up: hit_t (17), hit_x, hit_y, hit_z (31 each),
    // face_axis (2), face_negative (1), 7 bits zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: hit
    output logic                   o_m_axis_tuser
);

    localparam int TW  = FRAC_BITS + 3;
    localparam int LAT = FRAC_BITS + 5 + MERGE_LAT;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipe advances unless the output register
    // holds a result that the sink is not taking. Bubbles flow with it.
    // ------------------------------------------------------------------
    logic           w_ce;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    assign w_ce            = !(r_vld[LAT-1] && !i_m_axis_tready);
    assign o_s_axis_tready = w_ce;

    always_comb begin
        n_vld = {r_vld[LAT-2:0], i_s_axis_tvalid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= n_vld;
        end
    end

    // ------------------------------------------------------------------
    // Axis lanes: one per coordinate, each with its own dividers
    // ------------------------------------------------------------------
    t_axis_flags               w_flags [NUM_AXES];
    logic signed [DIFF_W-1:0]  w_dir   [NUM_AXES];
    logic signed [COORD_W-1:0] w_st    [NUM_AXES];
    logic signed [TW-1:0]      w_t1    [NUM_AXES];
    logic signed [TW-1:0]      w_t2    [NUM_AXES];

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        sbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk   (i_clk),
            .i_ce    (w_ce),
            .i_thr   (r_thr),
            .i_st    ($signed(i_s_axis_tdata[COORD_W*a +: COORD_W])),
            .i_en    ($signed(i_s_axis_tdata[COORD_W*(a+3) +: COORD_W])),
            .i_lo    ($signed(i_s_axis_tdata[COORD_W*(a+6) +: COORD_W])),
            .i_hi    ($signed(i_s_axis_tdata[COORD_W*(a+9) +: COORD_W])),
            .o_flags (w_flags[a]),
            .o_dir   (w_dir[a]),
            .o_st    (w_st[a]),
            .o_t1    (w_t1[a]),
            .o_t2    (w_t2[a])
        );
    end

    // ------------------------------------------------------------------
    // Merge: interval clip, face pick, entry point; last stage is the
    // output register
    // ------------------------------------------------------------------
    logic                      w_hit;
    logic [HIT_T_W-1:0]        w_hit_t;
    logic signed [COORD_W-1:0] w_hit_pt [NUM_AXES];
    t_axis                     w_face_axis;
    logic                      w_face_neg;

    sbsi_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .i_clk       (i_clk),
        .i_ce        (w_ce),
        .i_flags     (w_flags),
        .i_dir       (w_dir),
        .i_st        (w_st),
        .i_t1        (w_t1),
        .i_t2        (w_t2),
        .o_hit       (w_hit),
        .o_hit_t     (w_hit_t),
        .o_hit_pt    (w_hit_pt),
        .o_face_axis (w_face_axis),
        .o_face_neg  (w_face_neg)
    );

    assign o_m_axis_tvalid = r_vld[LAT-1];
    assign o_m_axis_tuser  = w_hit;
    assign o_m_axis_tdata  = {7'b0, w_face_neg, w_face_axis,
                              w_hit_pt[2], w_hit_pt[1], w_hit_pt[0], w_hit_t};

`ifndef SYNTH
    // a miss carries no face and no entry parameter
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
            (o_m_axis_tdata[111:110] == AXIS_NONE && !o_m_axis_tdata[112]
             && o_m_axis_tdata[16:0] == '0))
        else $error("miss result carries face or entry data");

    // without a face axis there is no normal sign
    a_no_face_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[111:110] == AXIS_NONE) |->
            !o_m_axis_tdata[112])
        else $error("face sign set without face axis");

    // a held result keeps the pipe frozen, so the request side stalls
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("request accepted while result stalled");
`endif

endmodule

/* rtl/sbsi_div.sv */
// ----------------------------------------------------------------------------
// sbsi_div
// Pipelined restoring divider: slab parameter (num << FRAC_BITS) / den,
// truncated toward zero and saturated to +/- 2.0.
// ----------------------------------------------------------------------------
module sbsi_div
    import sbsi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_ce,
    input  logic signed [DIFF_W-1:0]    i_num,
    input  logic signed [DIFF_W-1:0]    i_den,
    output logic signed [FRAC_BITS+2:0] o_quo
);

    localparam int NSTEP = FRAC_BITS + 2;
    localparam int NW    = DIFF_W + FRAC_BITS;
    localparam int TW    = FRAC_BITS + 3;
    localparam logic [TW-1:0] LIM = {3'b010, {FRAC_BITS{1'b0}}};

    logic [NW-1:0]     r_rem [0:NSTEP];
    logic [NSTEP-1:0]  r_q   [0:NSTEP];
    logic [DIFF_W-1:0] r_den [0:NSTEP];
    logic              r_ovf [0:NSTEP];
    logic              r_neg [0:NSTEP];
    logic signed [TW-1:0] r_quo;

    logic [DIFF_W-1:0] w_a;
    logic [DIFF_W-1:0] w_d;

    assign w_a = i_num[DIFF_W-1] ? DIFF_W'(-i_num) : DIFF_W'(i_num);
    assign w_d = i_den[DIFF_W-1] ? DIFF_W'(-i_den) : DIFF_W'(i_den);

    // magnitudes; a quotient of 4.0 or more is flagged here and saturates at the output
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= {w_a, {FRAC_BITS{1'b0}}};
            r_q[0]   <= '0;
            r_den[0] <= w_d;
            r_ovf[0] <= {2'b00, w_a} >= {w_d, 2'b00};
            r_neg[0] <= i_num[DIFF_W-1] ^ i_den[DIFF_W-1];
        end
    end

    // one quotient bit per stage, MSB first
    for (genvar j = 0; j < NSTEP; j++) begin : g_step
        localparam int K = NSTEP - 1 - j;
        logic [NW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = NW'(r_den[j]) << K;
        assign w_ge = r_rem[j] >= w_sh;
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[j+1] <= w_ge ? (r_rem[j] - w_sh) : r_rem[j];
                r_q[j+1]   <= r_q[j] | (w_ge ? (NSTEP'(1) << K) : NSTEP'(0));
                r_den[j+1] <= r_den[j];
                r_ovf[j+1] <= r_ovf[j];
                r_neg[j+1] <= r_neg[j];
            end
        end
    end

    logic [TW-1:0] w_mag;
    assign w_mag = (r_ovf[NSTEP] || ({1'b0, r_q[NSTEP]} > LIM)) ? LIM : {1'b0, r_q[NSTEP]};

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_quo <= r_neg[NSTEP] ? -$signed(w_mag) : $signed(w_mag);
        end
    end

    assign o_quo = r_quo;

endmodule

/* rtl/sbsi_lane.sv */
// ----------------------------------------------------------------------------
// sbsi_lane
// One axis: direction, slab offsets, parallel test and two slab dividers.
// ----------------------------------------------------------------------------
module sbsi_lane
    import sbsi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_ce,
    input  logic [THR_W-1:0]            i_thr,
    input  logic signed [COORD_W-1:0]   i_st,
    input  logic signed [COORD_W-1:0]   i_en,
    input  logic signed [COORD_W-1:0]   i_lo,
    input  logic signed [COORD_W-1:0]   i_hi,
    output t_axis_flags                 o_flags,
    output logic signed [DIFF_W-1:0]    o_dir,
    output logic signed [COORD_W-1:0]   o_st,
    output logic signed [FRAC_BITS+2:0] o_t1,
    output logic signed [FRAC_BITS+2:0] o_t2
);

    localparam int DIV_LAT = FRAC_BITS + 4;

    logic signed [DIFF_W-1:0]  r_dir;
    logic signed [DIFF_W-1:0]  r_dlo;
    logic signed [DIFF_W-1:0]  r_dhi;
    logic signed [COORD_W-1:0] r_st;
    logic                      r_out;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_dir <= DIFF_W'(i_en) - DIFF_W'(i_st);
            r_dlo <= DIFF_W'(i_lo) - DIFF_W'(i_st);
            r_dhi <= DIFF_W'(i_hi) - DIFF_W'(i_st);
            r_st  <= i_st;
            r_out <= (i_st < i_lo) || (i_st > i_hi);
        end
    end

    logic [DIFF_W-1:0] w_mag;
    logic              w_par;
    assign w_mag = r_dir[DIFF_W-1] ? DIFF_W'(-r_dir) : DIFF_W'(r_dir);
    assign w_par = (r_dir == '0) || (w_mag < {{(DIFF_W-THR_W){1'b0}}, i_thr});

    sbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
        .i_clk (i_clk),
        .i_ce  (i_ce),
        .i_num (r_dlo),
        .i_den (r_dir),
        .o_quo (o_t1)
    );

    sbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
        .i_clk (i_clk),
        .i_ce  (i_ce),
        .i_num (r_dhi),
        .i_den (r_dir),
        .o_quo (o_t2)
    );

    // hold the side data level with the dividers
    t_axis_flags               r_sd_flags [0:DIV_LAT-1];
    logic signed [DIFF_W-1:0]  r_sd_dir   [0:DIV_LAT-1];
    logic signed [COORD_W-1:0] r_sd_st    [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sd_flags[0] <= '{par: w_par, outside: r_out};
            r_sd_dir[0]   <= r_dir;
            r_sd_st[0]    <= r_st;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sd_flags[k] <= r_sd_flags[k-1];
                r_sd_dir[k]   <= r_sd_dir[k-1];
                r_sd_st[k]    <= r_sd_st[k-1];
            end
        end
    end

    assign o_flags = r_sd_flags[DIV_LAT-1];
    assign o_dir   = r_sd_dir[DIV_LAT-1];
    assign o_st    = r_sd_st[DIV_LAT-1];

endmodule

/* rtl/sbsi_merge.sv */
// ----------------------------------------------------------------------------
// sbsi_merge
// Combines the three lanes: interval clipping, face choice and entry point.
// ----------------------------------------------------------------------------
module sbsi_merge
    import sbsi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_ce,
    input  t_axis_flags                 i_flags [NUM_AXES],
    input  logic signed [DIFF_W-1:0]    i_dir   [NUM_AXES],
    input  logic signed [COORD_W-1:0]   i_st    [NUM_AXES],
    input  logic signed [FRAC_BITS+2:0] i_t1    [NUM_AXES],
    input  logic signed [FRAC_BITS+2:0] i_t2    [NUM_AXES],
    output logic                        o_hit,
    output logic [HIT_T_W-1:0]          o_hit_t,
    output logic signed [COORD_W-1:0]   o_hit_pt [NUM_AXES],
    output t_axis                       o_face_axis,
    output logic                        o_face_neg
);

    localparam int TW = FRAC_BITS + 3;
    localparam int PW = DIFF_W + FRAC_BITS + 2;
    localparam logic signed [TW-1:0] ONE = TW'(1) << FRAC_BITS;

    // stage 1: order each slab pair
    t_axis_flags               r1_flags [NUM_AXES];
    logic signed [DIFF_W-1:0]  r1_dir   [NUM_AXES];
    logic signed [COORD_W-1:0] r1_st    [NUM_AXES];
    logic signed [TW-1:0]      r1_lo    [NUM_AXES];
    logic signed [TW-1:0]      r1_hi    [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r1_flags[i] <= i_flags[i];
                r1_dir[i]   <= i_dir[i];
                r1_st[i]    <= i_st[i];
                r1_lo[i]    <= (i_t1[i] > i_t2[i]) ? i_t2[i] : i_t1[i];
                r1_hi[i]    <= (i_t1[i] > i_t2[i]) ? i_t1[i] : i_t2[i];
            end
        end
    end

    // stage 2: clip the running interval in x, y, z order
    logic signed [TW-1:0] v_tmin;
    logic signed [TW-1:0] v_tmax;
    t_axis                v_axis;
    logic                 v_miss;
    logic                 v_fneg;

    always_comb begin
        v_tmin = '0;
        v_tmax = ONE;
        v_axis = AXIS_NONE;
        v_miss = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (r1_flags[i].par) begin
                if (r1_flags[i].outside) begin
                    v_miss = 1'b1;
                end
            end else begin
                if (r1_lo[i] > v_tmin) begin
                    v_tmin = r1_lo[i];
                end
                if (r1_hi[i] < v_tmax) begin
                    v_tmax = r1_hi[i];
                end
                if (v_tmin == r1_lo[i]) begin
                    v_axis = AXIS_W'(i);
                end
                if (v_tmin > v_tmax) begin
                    v_miss = 1'b1;
                end
            end
        end
        unique case (v_axis)
            AXIS_X:  v_fneg = r1_dir[0] > 0;
            AXIS_Y:  v_fneg = r1_dir[1] > 0;
            AXIS_Z:  v_fneg = r1_dir[2] > 0;
            default: v_fneg = 1'b0;
        endcase
    end

    logic                      r2_miss;
    logic [FRAC_BITS:0]        r2_tmin;
    t_axis                     r2_axis;
    logic                      r2_fneg;
    logic signed [DIFF_W-1:0]  r2_dir [NUM_AXES];
    logic signed [COORD_W-1:0] r2_st  [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_miss <= v_miss;
            r2_tmin <= v_tmin[FRAC_BITS:0];
            r2_axis <= v_axis;
            r2_fneg <= v_fneg;
            r2_dir  <= r1_dir;
            r2_st   <= r1_st;
        end
    end

    // stage 3: scale direction by the entry parameter
    logic                      r3_miss;
    logic [FRAC_BITS:0]        r3_tmin;
    t_axis                     r3_axis;
    logic                      r3_fneg;
    logic signed [PW-1:0]      r3_prod [NUM_AXES];
    logic signed [COORD_W-1:0] r3_st   [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r3_miss <= r2_miss;
            r3_tmin <= r2_tmin;
            r3_axis <= r2_axis;
            r3_fneg <= r2_fneg;
            r3_st   <= r2_st;
            for (int i = 0; i < NUM_AXES; i++) begin
                r3_prod[i] <= PW'($signed({1'b0, r2_tmin})) * PW'(r2_dir[i]);
            end
        end
    end

    // stage 4: floor back to Q16.16 and offset by the start point
    logic signed [PW-1:0] w_sc [NUM_AXES];

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            w_sc[i] = r3_prod[i] >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_hit       <= !r3_miss;
            o_hit_t     <= r3_miss ? '0 : HIT_T_W'(r3_tmin);
            o_face_axis <= r3_miss ? AXIS_NONE : r3_axis;
            o_face_neg  <= !r3_miss && r3_fneg;
            for (int i = 0; i < NUM_AXES; i++) begin
                o_hit_pt[i] <= r3_miss ? '0 : (r3_st[i] + $signed(w_sc[i][COORD_W-1:0]));
            end
        end
    end

endmodule
